// ----- sv/lcad_pkg.sv -----
// shared types and constants of the tree lca distance engine
package lcad_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LVL_W      = $clog2(LOG_LEVELS);
  localparam int CNT_W      = NODE_W + 1;
  localparam int EDGE_CAP   = MAX_NODES - 1;
  localparam int WT_W       = 16;
  localparam int DIST_W     = 27;
  localparam int JT_DEPTH   = MAX_NODES * LOG_LEVELS;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_BUILD    = 2'd1,
    OP_DIST     = 2'd2,
    OP_ANC      = 2'd3
  } op_e;

  typedef enum logic {
    CFG_NODE_COUNT = 1'b0,
    CFG_ROOT_NODE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WT_W-1:0]   edge_weight;
    logic [NODE_W-1:0] climb_steps;
  } req_t;

  typedef struct packed {
    op_e               kind;
    logic [NODE_W-1:0] found_node;
    logic              node_valid;
    logic [DIST_W-1:0] path_distance;
    logic              store_full;
  } res_t;

  // per-node record of the walk
  typedef struct packed {
    logic              visited;
    logic              has_par;
    logic [NODE_W-1:0] parent;
    logic [NODE_W-1:0] depth;
    logic [DIST_W-1:0] rdist;
  } node_rec_t;

  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WT_W-1:0]   w;
  } edge_rec_t;

  // stack entry: node and the edge index to resume the scan at
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] resume;
  } stk_rec_t;

  // jump table entry, valid low means no node
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } jt_ent_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLR, ST_ROOT, ST_POP, ST_TOP, ST_TOPD, ST_EREQ, ST_EDAT,
    ST_VIS, ST_PUSH, ST_J0R, ST_J0W, ST_JR1, ST_JR2, ST_JW, ST_QA, ST_QB,
    ST_CLIMB, ST_CW, ST_LA, ST_LB, ST_LC, ST_LP, ST_XD
  } state_e;

endpackage

// ----- sv/lcad_ram.sv -----
// generic simple dual-port ram with registered read
module lcad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- sv/tree_lca_distance_engine_unit.sv -----
// top level of the tree lca distance engine
// Weighted tree engine with binary-lifting lowest common ancestor lookup. Raise start_i
// while busy_o is low to issue a request; exactly one result follows, shown on res_o for
// a single cycle with done_o high, and the receiver cannot stall it. An edge add writes the
// edge store, or reports store_full when it is full. A build first clears the node memory,
// walks the tree depth first over the edge store (each reached node scans the store once,
// with stack work around it), fills jump level 0 from the parents and then levels 1 to 9
// from the level below. Each memory has a single read port. A query climbs the deeper node
// by the set bits of the depth difference, one table read per set bit, then descends the
// levels while the ancestors differ. The user must write node_count and root_node through
// cfg_we_i only while busy_o is low; the block itself does not enforce this.
module tree_lca_distance_engine_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  lcad_pkg::req_t           req_i,
  output logic                     done_o,
  output lcad_pkg::res_t           res_o,
  input  logic                     cfg_we_i,
  input  lcad_pkg::cfg_idx_e       cfg_idx_i,
  input  logic [lcad_pkg::CNT_W-1:0] cfg_wdata_i
);
  import lcad_pkg::*;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  res_t                res_q, res_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    node_count_q;
  logic [NODE_W-1:0]   root_q;
  logic [NODE_W-1:0]   edge_cnt_q, edge_cnt_d;
  logic                built_q, built_d;
  logic [CNT_W-1:0]    sp_q, sp_d;
  logic [NODE_W-1:0]   e_q, e_d;
  logic [NODE_W-1:0]   top_q, top_d;
  logic [NODE_W-1:0]   tdep_q, tdep_d;
  logic [DIST_W-1:0]   tdist_q, tdist_d;
  logic [NODE_W-1:0]   oth_q, oth_d;
  logic [WT_W-1:0]     w_q, w_d;
  logic [NODE_W-1:0]   v_q, v_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [NODE_W-1:0]   mask_q, mask_d;
  logic [NODE_W-1:0]   cur_q, cur_d;
  logic [NODE_W-1:0]   depa_q, depa_d;
  logic [DIST_W-1:0]   dista_q, dista_d;
  logic [DIST_W:0]     dsum_q, dsum_d;
  jt_ent_t             ja_q, ja_d;

  // memory ports
  logic                edge_we, edge_re;
  logic [NODE_W-1:0]   edge_waddr, edge_raddr;
  edge_rec_t           edge_wdata;
  logic [$bits(edge_rec_t)-1:0] edge_rdata;
  edge_rec_t           edge_rd;
  logic                node_we, node_re;
  logic [NODE_W-1:0]   node_waddr, node_raddr;
  node_rec_t           node_wdata;
  logic [$bits(node_rec_t)-1:0] node_rdata;
  node_rec_t           node_rd;
  logic                stk_we, stk_re;
  logic [NODE_W-1:0]   stk_waddr, stk_raddr;
  stk_rec_t            stk_wdata;
  logic [$bits(stk_rec_t)-1:0] stk_rdata;
  stk_rec_t            stk_rd;
  logic                jt_we, jt_re;
  logic [LVL_W+NODE_W-1:0] jt_waddr, jt_raddr;
  jt_ent_t             jt_wdata;
  logic [$bits(jt_ent_t)-1:0] jt_rdata;
  jt_ent_t             jt_rd;

  // helper terms
  logic [CNT_W-1:0]    n_eff;
  logic                root_in;
  logic                e_hit;
  logic [NODE_W-1:0]   e_other;
  logic                node_in;
  logic                walk_end;
  logic                v_last;
  logic                adv_last;
  logic                anc_fail;
  logic                jt_differ;
  logic [CNT_W-1:0]    sp_m1;
  logic [LVL_W-1:0]    lvl_m1;
  logic [NODE_W-1:0]   lc_cur;
  logic [DIST_W:0]     dist_raw;

  assign edge_rd = edge_rec_t'(edge_rdata);
  assign node_rd = node_rec_t'(node_rdata);
  assign stk_rd  = stk_rec_t'(stk_rdata);
  assign jt_rd   = jt_ent_t'(jt_rdata);

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
  end

  assign root_in   = {1'b0, root_q} < n_eff;
  assign e_hit     = ({1'b0, edge_rd.a} < n_eff) && ({1'b0, edge_rd.b} < n_eff) &&
                     ((edge_rd.a == top_q) || (edge_rd.b == top_q));
  assign e_other   = (edge_rd.a == top_q) ? edge_rd.b : edge_rd.a;
  assign node_in   = built_q && node_rd.visited;
  assign walk_end  = e_q >= edge_cnt_q;
  assign v_last    = v_q == '1;
  assign adv_last  = v_last && (lvl_q == LVL_W'(LOG_LEVELS - 1));
  assign anc_fail  = !node_in || (req_q.climb_steps > node_rd.depth);
  assign jt_differ = ja_q != jt_rd;
  assign sp_m1     = sp_q - CNT_W'(1);
  assign lvl_m1    = lvl_q - LVL_W'(1);
  assign lc_cur    = jt_differ ? ja_q.node : cur_q;
  assign dist_raw  = dsum_q - {node_rd.rdist, 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.op)
            OP_ADD_EDGE: state_d = ST_IDLE;
            OP_BUILD:    state_d = ST_CLR;
            default:     state_d = ST_QA;
          endcase
        end
      end
      ST_CLR:   state_d = v_last ? ST_ROOT : ST_CLR;
      ST_ROOT:  state_d = ST_POP;
      ST_POP:   state_d = (sp_q == '0) ? ST_J0R : ST_TOP;
      ST_TOP:   state_d = ST_TOPD;
      ST_TOPD:  state_d = ST_EREQ;
      ST_EREQ:  state_d = walk_end ? ST_POP : ST_EDAT;
      ST_EDAT:  state_d = e_hit ? ST_VIS : ST_EREQ;
      ST_VIS:   state_d = node_rd.visited ? ST_EREQ : ST_PUSH;
      ST_PUSH:  state_d = ST_EREQ;
      ST_J0R:   state_d = ST_J0W;
      ST_J0W:   state_d = v_last ? ST_JR1 : ST_J0R;
      ST_JR1:   state_d = ST_JR2;
      ST_JR2: begin
        if (jt_rd.valid) begin
          state_d = ST_JW;
        end else begin
          state_d = adv_last ? ST_IDLE : ST_JR1;
        end
      end
      ST_JW:    state_d = adv_last ? ST_IDLE : ST_JR1;
      ST_QA: begin
        if (req_q.op == OP_ANC) begin
          state_d = anc_fail ? ST_IDLE : ST_CLIMB;
        end else begin
          state_d = node_in ? ST_QB : ST_IDLE;
        end
      end
      ST_QB:    state_d = node_in ? ST_CLIMB : ST_IDLE;
      ST_CLIMB: begin
        if (mask_q == '0) begin
          if (req_q.op == OP_ANC) begin
            state_d = ST_IDLE;
          end else if (cur_q == oth_q) begin
            state_d = ST_XD;
          end else begin
            state_d = ST_LA;
          end
        end else begin
          state_d = mask_q[0] ? ST_CW : ST_CLIMB;
        end
      end
      ST_CW:    state_d = jt_rd.valid ? ST_CLIMB : ST_IDLE;
      ST_LA:    state_d = ST_LB;
      ST_LB:    state_d = ST_LC;
      ST_LC:    state_d = (lvl_q == '0) ? ST_LP : ST_LA;
      ST_LP:    state_d = node_rd.has_par ? ST_XD : ST_IDLE;
      ST_XD:    state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d      = req_q;
    res_d      = res_q;
    done_d     = 1'b0;
    edge_cnt_d = edge_cnt_q;
    built_d    = built_q;
    sp_d       = sp_q;
    e_d        = e_q;
    top_d      = top_q;
    tdep_d     = tdep_q;
    tdist_d    = tdist_q;
    oth_d      = oth_q;
    w_d        = w_q;
    v_d        = v_q;
    lvl_d      = lvl_q;
    mask_d     = mask_q;
    cur_d      = cur_q;
    depa_d     = depa_q;
    dista_d    = dista_q;
    dsum_d     = dsum_q;
    ja_d       = ja_q;
    edge_we    = 1'b0;
    edge_waddr = edge_cnt_q;
    edge_wdata = '0;
    edge_re    = 1'b0;
    edge_raddr = e_q;
    node_we    = 1'b0;
    node_waddr = v_q;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = v_q;
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[NODE_W-1:0];
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = sp_m1[NODE_W-1:0];
    jt_we      = 1'b0;
    jt_waddr   = {lvl_q, v_q};
    jt_wdata   = '0;
    jt_re      = 1'b0;
    jt_raddr   = {lvl_m1, v_q};

    case (state_q)
      // take a request
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          case (req_i.op)
            OP_ADD_EDGE: begin
              res_d      = '0;
              res_d.kind = req_i.op;
              done_d     = 1'b1;
              if (edge_cnt_q == NODE_W'(EDGE_CAP)) begin
                res_d.store_full = 1'b1;
              end else begin
                edge_we    = 1'b1;
                edge_wdata = '{a: req_i.node_a, b: req_i.node_b, w: req_i.edge_weight};
                edge_cnt_d = edge_cnt_q + NODE_W'(1);
              end
            end
            OP_BUILD: v_d = '0;
            default: begin
              node_re    = 1'b1;
              node_raddr = req_i.node_a;
            end
          endcase
        end
      end
      // clear the node records
      ST_CLR: begin
        node_we = 1'b1;
        v_d     = v_q + NODE_W'(1);
      end
      // seed the walk with the root
      ST_ROOT: begin
        if (root_in) begin
          node_we            = 1'b1;
          node_waddr         = root_q;
          node_wdata.visited = 1'b1;
          stk_we             = 1'b1;
          stk_waddr          = '0;
          stk_wdata          = '{node: root_q, resume: '0};
          sp_d               = CNT_W'(1);
        end else begin
          sp_d = '0;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          v_d = '0;
        end else begin
          stk_re = 1'b1;
        end
      end
      ST_TOP: begin
        top_d      = stk_rd.node;
        e_d        = stk_rd.resume;
        node_re    = 1'b1;
        node_raddr = stk_rd.node;
      end
      ST_TOPD: begin
        tdep_d  = node_rd.depth;
        tdist_d = node_rd.rdist;
      end
      // scan the edge store from the resume point
      ST_EREQ: begin
        if (walk_end) begin
          sp_d = sp_m1;
        end else begin
          edge_re = 1'b1;
        end
      end
      ST_EDAT: begin
        if (e_hit) begin
          oth_d      = e_other;
          w_d        = edge_rd.w;
          node_re    = 1'b1;
          node_raddr = e_other;
        end else begin
          e_d = e_q + NODE_W'(1);
        end
      end
      // mark the child and save where to resume
      ST_VIS: begin
        if (node_rd.visited) begin
          e_d = e_q + NODE_W'(1);
        end else begin
          node_we    = 1'b1;
          node_waddr = oth_q;
          node_wdata = '{visited: 1'b1, has_par: 1'b1, parent: top_q,
                         depth: tdep_q + NODE_W'(1),
                         rdist: tdist_q + DIST_W'(w_q)};
          stk_we     = 1'b1;
          stk_wdata  = '{node: top_q, resume: e_q + NODE_W'(1)};
        end
      end
      ST_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = sp_q[NODE_W-1:0];
        stk_wdata = '{node: oth_q, resume: '0};
        sp_d      = sp_q + CNT_W'(1);
        top_d     = oth_q;
        tdep_d    = tdep_q + NODE_W'(1);
        tdist_d   = tdist_q + DIST_W'(w_q);
        e_d       = '0;
      end
      // jump level zero from parents
      ST_J0R: begin
        node_re = 1'b1;
      end
      ST_J0W: begin
        jt_we    = 1'b1;
        jt_waddr = {LVL_W'(0), v_q};
        if (node_rd.visited && node_rd.has_par) begin
          jt_wdata = '{valid: 1'b1, node: node_rd.parent};
        end
        v_d = v_q + NODE_W'(1);
        if (v_last) begin
          lvl_d = LVL_W'(1);
        end
      end
      // higher levels from the level below
      ST_JR1: begin
        jt_re = 1'b1;
      end
      ST_JR2, ST_JW: begin
        if (state_q == ST_JR2 && jt_rd.valid) begin
          jt_re    = 1'b1;
          jt_raddr = {lvl_m1, jt_rd.node};
        end else begin
          jt_we    = 1'b1;
          jt_wdata = (state_q == ST_JW) ? jt_rd : '0;
          v_d      = v_q + NODE_W'(1);
          if (v_last) begin
            lvl_d = lvl_q + LVL_W'(1);
          end
          if (adv_last) begin
            built_d          = 1'b1;
            done_d           = 1'b1;
            res_d            = '0;
            res_d.kind       = OP_BUILD;
            res_d.found_node = root_q;
            res_d.node_valid = root_in;
          end
        end
      end
      // first query node
      ST_QA: begin
        depa_d  = node_rd.depth;
        dista_d = node_rd.rdist;
        res_d      = '0;
        res_d.kind = req_q.op;
        if (req_q.op == OP_ANC) begin
          if (anc_fail) begin
            done_d = 1'b1;
          end else begin
            cur_d  = req_q.node_a;
            mask_d = req_q.climb_steps;
            lvl_d  = '0;
          end
        end else if (!node_in) begin
          done_d = 1'b1;
        end else begin
          node_re    = 1'b1;
          node_raddr = req_q.node_b;
        end
      end
      // second query node, deeper one climbs
      ST_QB: begin
        if (!node_in) begin
          done_d = 1'b1;
        end else begin
          dsum_d = {1'b0, dista_q} + {1'b0, node_rd.rdist};
          lvl_d  = '0;
          if (depa_q < node_rd.depth) begin
            cur_d  = req_q.node_b;
            oth_d  = req_q.node_a;
            mask_d = node_rd.depth - depa_q;
          end else begin
            cur_d  = req_q.node_a;
            oth_d  = req_q.node_b;
            mask_d = depa_q - node_rd.depth;
          end
        end
      end
      // climb one set bit of the step count per table read
      ST_CLIMB: begin
        if (mask_q == '0) begin
          if (req_q.op == OP_ANC) begin
            done_d           = 1'b1;
            res_d.found_node = cur_q;
            res_d.node_valid = 1'b1;
          end else if (cur_q == oth_q) begin
            node_re    = 1'b1;
            node_raddr = cur_q;
          end else begin
            lvl_d = LVL_W'(LOG_LEVELS - 1);
          end
        end else if (mask_q[0]) begin
          jt_re    = 1'b1;
          jt_raddr = {lvl_q, cur_q};
        end else begin
          mask_d = mask_q >> 1;
          lvl_d  = lvl_q + LVL_W'(1);
        end
      end
      ST_CW: begin
        if (!jt_rd.valid) begin
          done_d = 1'b1;
        end else begin
          cur_d  = jt_rd.node;
          mask_d = mask_q >> 1;
          lvl_d  = lvl_q + LVL_W'(1);
        end
      end
      // descend while the ancestors differ
      ST_LA: begin
        jt_re    = 1'b1;
        jt_raddr = {lvl_q, cur_q};
      end
      ST_LB: begin
        ja_d     = jt_rd;
        jt_re    = 1'b1;
        jt_raddr = {lvl_q, oth_q};
      end
      ST_LC: begin
        if (jt_differ) begin
          cur_d = ja_q.node;
          oth_d = jt_rd.node;
        end
        if (lvl_q == '0) begin
          node_re    = 1'b1;
          node_raddr = lc_cur;
        end else if (!(jt_differ && lvl_q == LVL_W'(LOG_LEVELS - 1))) begin
          lvl_d = lvl_m1;
        end
      end
      ST_LP: begin
        if (!node_rd.has_par) begin
          done_d = 1'b1;
        end else begin
          cur_d      = node_rd.parent;
          node_re    = 1'b1;
          node_raddr = node_rd.parent;
        end
      end
      // path length through the common ancestor
      ST_XD: begin
        done_d           = 1'b1;
        res_d.found_node = cur_q;
        res_d.node_valid = 1'b1;
        res_d.path_distance = dist_raw[DIST_W] ? '1 : dist_raw[DIST_W-1:0];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_q       <= 1'b0;
      node_count_q <= CNT_W'(1);
      root_q       <= '0;
      edge_cnt_q   <= '0;
      built_q      <= 1'b0;
      sp_q         <= '0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      edge_cnt_q <= edge_cnt_d;
      built_q    <= built_d;
      sp_q       <= sp_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_COUNT: node_count_q <= cfg_wdata_i;
          CFG_ROOT_NODE:  root_q       <= cfg_wdata_i[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    e_q     <= e_d;
    top_q   <= top_d;
    tdep_q  <= tdep_d;
    tdist_q <= tdist_d;
    oth_q   <= oth_d;
    w_q     <= w_d;
    v_q     <= v_d;
    lvl_q   <= lvl_d;
    mask_q  <= mask_d;
    cur_q   <= cur_d;
    depa_q  <= depa_d;
    dista_q <= dista_d;
    dsum_q  <= dsum_d;
    ja_q    <= ja_d;
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  // edge store
  lcad_ram #(.Width($bits(edge_rec_t)), .Depth(EDGE_CAP)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // node records
  lcad_ram #(.Width($bits(node_rec_t)), .Depth(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // walk stack
  lcad_ram #(.Width($bits(stk_rec_t)), .Depth(MAX_NODES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // jump table, level in the upper address bits
  lcad_ram #(.Width($bits(jt_ent_t)), .Depth(JT_DEPTH)) u_jt_ram (
    .clk_i   (clk_i),
    .we_i    (jt_we),
    .waddr_i (jt_waddr),
    .wdata_i (jt_wdata),
    .re_i    (jt_re),
    .raddr_i (jt_raddr),
    .rdata_o (jt_rdata)
  );

endmodule
